/* src/dq_pkg.sv */
package dq_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 6;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;

  typedef enum logic [KIND_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4,
    OP_WRITE      = 3'd5,
    OP_FIND       = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCAN,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic rd_load;
    logic scan_step;
    logic scan_hit;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic empty;
    logic pos_ok;
    logic match;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

/* src/dq_ctrl.sv */
module dq_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  dq_pkg::sts_t sts_i,
  output dq_pkg::cmd_t cmd_o
);
  import dq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        priority if (sts_i.op == OP_READ && sts_i.pos_ok) begin
          state_nxt = S_RDWAIT;
        end else if (sts_i.op == OP_FIND && !sts_i.empty) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_RDWAIT: begin
        cmd_o.rd_load = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_SCAN: begin
        priority if (sts_i.match) begin
          cmd_o.scan_hit = 1'b1;
          state_nxt      = S_FINISH;
        end else if (sts_i.scan_last) begin
          state_nxt = S_FINISH;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* src/dq_datapath.sv */
module dq_datapath #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dq_pkg::cmd_t                  cmd_i,
  output dq_pkg::sts_t                  sts_o,
  input  logic [dq_pkg::KIND_W-1:0]     in_kind,
  input  logic [dq_pkg::POS_W-1:0]      in_position,
  input  logic [dq_pkg::WORD_W-1:0]     in_data_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dq_pkg::WORD_W-1:0]     out_data_out,
  output logic [dq_pkg::POS_W-1:0]      out_found_index,
  output logic [dq_pkg::STATUS_W-1:0]   out_status,
  output logic [dq_pkg::OCC_W-1:0]      out_occupancy
);
  import dq_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  op_t                   op_r, op_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] word_r, word_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         front_r, front_nxt;
  logic [AW-1:0]         scan_idx_r, scan_idx_nxt;
  logic [AW-1:0]         scan_slot_r, scan_slot_nxt;
  logic [WORD_W-1:0]     res_data_r, res_data_nxt;
  logic [POS_W-1:0]      res_idx_r, res_idx_nxt;
  stat_t                 res_status_r, res_status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]     out_data_r, out_data_nxt;
  logic [POS_W-1:0]      out_idx_r, out_idx_nxt;
  stat_t                 out_status_r, out_status_nxt;
  logic [OCC_W-1:0]      out_occ_r, out_occ_nxt;
  logic [DATA_WIDTH-1:0] rd_data_r;

  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [AW-1:0]         pos_slot, back_slot, front_dec, front_inc, scan_inc;
  logic                  empty, full, pos_ok, pos_eq, out_free;

  assign empty     = (count_r == '0);
  assign full      = (count_r == FULL_CNT);
  assign pos_ok    = CMPW'(pos_r) < CMPW'(count_r);
  assign pos_eq    = CMPW'(pos_r) == CMPW'(count_r);
  assign pos_slot  = wrap_add(front_r, AW'(pos_r));
  assign back_slot = wrap_add(front_r, AW'(count_r));
  assign front_dec = (front_r == '0) ? LAST_SLOT : front_r - AW'(1);
  assign front_inc = (front_r == LAST_SLOT) ? '0 : front_r + AW'(1);
  assign scan_inc  = (scan_slot_r == LAST_SLOT) ? '0 : scan_slot_r + AW'(1);
  assign out_free  = !out_valid_r || out_ready;

  assign sts_o.op        = op_r;
  assign sts_o.empty     = empty;
  assign sts_o.pos_ok    = pos_ok;
  assign sts_o.match     = (rd_data_r == word_r);
  assign sts_o.scan_last = (CW'(scan_idx_r) + CW'(1)) == count_r;
  assign sts_o.out_free  = out_free;

  always_comb begin
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    word_nxt       = word_r;
    count_nxt      = count_r;
    front_nxt      = front_r;
    scan_idx_nxt   = scan_idx_r;
    scan_slot_nxt  = scan_slot_r;
    res_data_nxt   = res_data_r;
    res_idx_nxt    = res_idx_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_idx_nxt    = out_idx_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    wr_en          = 1'b0;
    wr_addr        = pos_slot;
    rd_en          = 1'b0;
    rd_addr        = pos_slot;

    if (cmd_i.capture) begin
      op_nxt   = op_t'(in_kind);
      pos_nxt  = in_position;
      word_nxt = DATA_WIDTH'(in_data_in);
    end

    if (cmd_i.exec) begin
      res_data_nxt   = '0;
      res_idx_nxt    = '0;
      res_status_nxt = STAT_OK;
      unique case (op_r)
        OP_PUSH_FRONT: begin
          if (full) begin
            res_status_nxt = STAT_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = front_dec;
            front_nxt = front_dec;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            res_status_nxt = STAT_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = back_slot;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            res_status_nxt = STAT_EMPTY;
          end else begin
            front_nxt = front_inc;
            count_nxt = count_r - CW'(1);
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            res_status_nxt = STAT_EMPTY;
          end else begin
            count_nxt = count_r - CW'(1);
          end
        end
        OP_READ: begin
          if (pos_ok) begin
            rd_en = 1'b1;
          end else begin
            res_status_nxt = STAT_RANGE;
          end
        end
        OP_WRITE: begin
          priority if (pos_ok) begin
            wr_en = 1'b1;
          end else if (pos_eq) begin
            if (full) begin
              res_status_nxt = STAT_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end else begin
            res_status_nxt = STAT_RANGE;
          end
        end
        OP_FIND: begin
          res_status_nxt = STAT_EMPTY;
          rd_en          = 1'b1;
          rd_addr        = front_r;
          scan_idx_nxt   = '0;
          scan_slot_nxt  = front_r;
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.rd_load) begin
      res_data_nxt = WORD_W'(rd_data_r);
    end

    if (cmd_i.scan_step) begin
      rd_en         = 1'b1;
      rd_addr       = scan_inc;
      scan_idx_nxt  = scan_idx_r + AW'(1);
      scan_slot_nxt = scan_inc;
    end

    if (cmd_i.scan_hit) begin
      res_data_nxt   = WORD_W'(rd_data_r);
      res_idx_nxt    = POS_W'(scan_idx_r);
      res_status_nxt = STAT_OK;
    end

    if (cmd_i.out_load) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = res_data_r;
      out_idx_nxt    = res_idx_r;
      out_status_nxt = res_status_r;
      out_occ_nxt    = OCC_W'(count_r);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      front_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      front_r     <= front_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    word_r       <= word_nxt;
    scan_idx_r   <= scan_idx_nxt;
    scan_slot_r  <= scan_slot_nxt;
    res_data_r   <= res_data_nxt;
    res_idx_r    <= res_idx_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_idx_r    <= out_idx_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_data_out    = out_data_r;
  assign out_found_index = out_idx_r;
  assign out_status      = out_status_r;
  assign out_occupancy   = out_occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("count above depth");

  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, front_r} < DEPTH_W)
    else $error("front slot out of ring");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.out_load |-> out_free)
    else $error("result loaded over an untaken beat");

  a_count_exec: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_i.exec |=> count_r == $past(count_r))
    else $error("count moved outside execute");

endmodule

/* src/double_ended_queue_core.sv */
// double-ended queue of data words kept in a ring buffer memory
// input channel: in_valid/in_ready with in_kind, in_position, in_data_in;
//   kinds push front, push back, pop front, pop back, read, write, find
// result channel: out_valid/out_ready with out_data_out, out_found_index,
//   out_status and out_occupancy; exactly one result beat per input beat
// one item is handled at a time; in_ready is high while the controller idles
// an item passes from capture to execute; an in-range read then waits in a
//   state for the registered memory read, and a find compares the entries
//   one per cycle through the memory read port until a match or the last
//   entry; every item then waits until the output register is free
// a new item is accepted only after the result of the last one is loaded
//   into the output register
// the result sits in an output register; a stalled receiver holds the
//   finished item until taken, the next item may already be accepted
// reset (rst_n low, synchronous) empties the queue and drops any pending
//   result; memory contents are not cleared and need no clearing pass
module double_ended_queue_core #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dq_pkg::KIND_W-1:0]   in_kind,
  input  logic [dq_pkg::POS_W-1:0]    in_position,
  input  logic [dq_pkg::WORD_W-1:0]   in_data_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dq_pkg::WORD_W-1:0]   out_data_out,
  output logic [dq_pkg::POS_W-1:0]    out_found_index,
  output logic [dq_pkg::STATUS_W-1:0] out_status,
  output logic [dq_pkg::OCC_W-1:0]    out_occupancy
);
  import dq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_kind         (in_kind),
    .in_position     (in_position),
    .in_data_in      (in_data_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_out    (out_data_out),
    .out_found_index (out_found_index),
    .out_status      (out_status),
    .out_occupancy   (out_occupancy)
  );

endmodule
